/* rtl/tgrid_pkg.sv */
// ----------------------------------------------------------------------------
// tgrid_pkg
// Shared constants for the tile grid index and pixel snap block.
// ----------------------------------------------------------------------------
package tgrid_pkg;

    // tile and pixel sizes are carried at this fixed width
    localparam int SIZE_BITS = 41;
    localparam int CFG_IDX_W = 3;

    localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(256);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SIZE  = 3'd4;

    typedef logic [SIZE_BITS-1:0] t_size;

endpackage

/* rtl/tgrid_div.sv */
// ----------------------------------------------------------------------------
// tgrid_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with a
// sideband vector and the divisor carried along with each request.
// ----------------------------------------------------------------------------
module tgrid_div #(
    parameter int NUM_BITS  = 48,
    parameter int DEN_BITS  = 41,
    parameter int SIDE_BITS = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_vld,
    input  logic [NUM_BITS-1:0]  i_num,
    input  logic [DEN_BITS-1:0]  i_den,
    input  logic [SIDE_BITS-1:0] i_side,
    output logic                 o_vld,
    output logic [NUM_BITS-1:0]  o_quo,
    output logic [DEN_BITS-1:0]  o_rem,
    output logic [DEN_BITS-1:0]  o_den,
    output logic [SIDE_BITS-1:0] o_side
);

    logic                 r_vld  [0:NUM_BITS-1];
    logic [NUM_BITS-1:0]  r_num  [0:NUM_BITS-1];
    logic [DEN_BITS-1:0]  r_rem  [0:NUM_BITS-1];
    logic [DEN_BITS-1:0]  r_den  [0:NUM_BITS-1];
    logic [SIDE_BITS-1:0] r_side [0:NUM_BITS-1];

    for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
        logic                 w_vld;
        logic [NUM_BITS-1:0]  w_num;
        logic [DEN_BITS-1:0]  w_rem;
        logic [DEN_BITS-1:0]  w_den;
        logic [SIDE_BITS-1:0] w_side;
        logic [DEN_BITS:0]    w_trial;
        logic [DEN_BITS:0]    w_diff;
        logic                 w_ge;

        if (s == 0) begin : g_first
            assign w_vld  = i_vld;
            assign w_num  = i_num;
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[s-1];
            assign w_num  = r_num[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_trial = {w_rem, w_num[NUM_BITS-1]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_num[s]  <= {w_num[NUM_BITS-2:0], w_ge};
            r_rem[s]  <= w_ge ? w_diff[DEN_BITS-1:0] : w_trial[DEN_BITS-1:0];
            r_den[s]  <= w_den;
            r_side[s] <= w_side;
        end
    end

    assign o_vld  = r_vld[NUM_BITS-1];
    assign o_quo  = r_num[NUM_BITS-1];
    assign o_rem  = r_rem[NUM_BITS-1];
    assign o_den  = r_den[NUM_BITS-1];
    assign o_side = r_side[NUM_BITS-1];

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> (o_rem < o_den))
        else $error("divider remainder not below divisor");

    a_first_stage_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_rem[0] <= {{(DEN_BITS-1){1'b0}}, 1'b1}))
        else $error("first stage remainder wider than one bit");

    a_den_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |=> (r_den[1 % NUM_BITS] == $past(r_den[0]) || NUM_BITS == 1))
        else $error("divisor lost between stages");

endmodule

/* rtl/map_coord_to_tile_and_pixel_grid.sv */
// a request passes the input register, tile dividers, middle register, pixel dividers and output register
// throughput: one request per cycle, busy is always low
// latency is set mostly by the two pipelined divider chains (tile, then pixel)
// the receiver cannot stall, each result is shown for exactly one cycle
// synchronous active-low reset clears all valid bits and loads the register
// reset values (origin 0, sizes 256)
// ----------------------------------------------------------------------------
// map_coord_to_tile_and_pixel_grid
// Finds the tile column and row of a map point, the tile's upper-left corner
// and the point snapped to the pixel grid of that tile.
// ----------------------------------------------------------------------------
module map_coord_to_tile_and_pixel_grid #(
    parameter int COORD_BITS = 48,
    localparam int CFG_W = (COORD_BITS > tgrid_pkg::SIZE_BITS) ? COORD_BITS
                                                               : tgrid_pkg::SIZE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [COORD_BITS-1:0]      i_point_x,
    input  logic signed [COORD_BITS-1:0]      i_point_y,
    input  logic                              i_cfg_we,
    input  logic [tgrid_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]                  i_cfg_data,
    output logic                              o_valid,
    output logic signed [COORD_BITS-1:0]      o_tile_col,
    output logic signed [COORD_BITS-1:0]      o_tile_row,
    output logic signed [COORD_BITS:0]        o_tile_left,
    output logic signed [COORD_BITS:0]        o_tile_top,
    output logic signed [COORD_BITS:0]        o_snapped_x,
    output logic signed [COORD_BITS:0]        o_snapped_y
);

    import tgrid_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int WIDE  = CFG_W + 2;
    localparam int SIDE1 = CB + 2;
    localparam int SIDE2 = 3 * CB + 2;

    localparam logic [CB-1:0] COL_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic [CB-1:0] COL_MIN = {1'b1, {(CB-1){1'b0}}};

    // configuration registers
    logic [CB-1:0] r_ox, r_oy;
    t_size         r_tw, r_th, r_ps;
    t_size         w_cfg_size;

    assign w_cfg_size = (i_cfg_data[SIZE_BITS-1:0] == '0) ? SIZE_BITS'(1)
                                                          : i_cfg_data[SIZE_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ox <= '0;
            r_oy <= '0;
            r_tw <= SIZE_RESET;
            r_th <= SIZE_RESET;
            r_ps <= SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ORIGIN_X:    r_ox <= i_cfg_data[CB-1:0];
                REG_ORIGIN_Y:    r_oy <= i_cfg_data[CB-1:0];
                REG_TILE_WIDTH:  r_tw <= w_cfg_size;
                REG_TILE_HEIGHT: r_th <= w_cfg_size;
                REG_PIXEL_SIZE:  r_ps <= w_cfg_size;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input stage: offsets from the origin, y measured downward
    logic          r_in_vld;
    logic [CB:0]   r_dx, r_dy;
    logic [CB-1:0] r_in_px, r_in_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx    <= {i_point_x[CB-1], i_point_x} - {r_ox[CB-1], r_ox};
        r_dy    <= {r_oy[CB-1], r_oy} - {i_point_y[CB-1], i_point_y};
        r_in_px <= i_point_x;
        r_in_py <= i_point_y;
    end

    // floor division of signed n (less one when n is positive) by d as unsigned division of n or ~n
    logic          w_pos_x, w_pos_y, w_neg_x, w_neg_y;
    logic [CB:0]   w_nx, w_ny;
    logic [CB-1:0] w_mx, w_my;

    assign w_pos_x = !r_dx[CB] && (r_dx != '0);
    assign w_pos_y = !r_dy[CB] && (r_dy != '0);
    assign w_nx    = w_pos_x ? r_dx - (CB+1)'(1) : r_dx;
    assign w_ny    = w_pos_y ? r_dy - (CB+1)'(1) : r_dy;
    assign w_neg_x = w_nx[CB];
    assign w_neg_y = w_ny[CB];
    assign w_mx    = w_neg_x ? ~w_nx[CB-1:0] : w_nx[CB-1:0];
    assign w_my    = w_neg_y ? ~w_ny[CB-1:0] : w_ny[CB-1:0];

    logic             w_t_vld_x, w_t_vld_y;
    logic [CB-1:0]    w_t_quo_x, w_t_quo_y;
    t_size            w_t_rem_x, w_t_rem_y, w_t_den_x, w_t_den_y;
    logic [SIDE1-1:0] w_t_side_x, w_t_side_y;

    tgrid_div #(.NUM_BITS(CB), .DEN_BITS(SIZE_BITS), .SIDE_BITS(SIDE1)) u_tile_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_num   (w_mx),
        .i_den   (r_tw),
        .i_side  ({r_in_px, w_pos_x, w_neg_x}),
        .o_vld   (w_t_vld_x),
        .o_quo   (w_t_quo_x),
        .o_rem   (w_t_rem_x),
        .o_den   (w_t_den_x),
        .o_side  (w_t_side_x)
    );

    tgrid_div #(.NUM_BITS(CB), .DEN_BITS(SIZE_BITS), .SIDE_BITS(SIDE1)) u_tile_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_in_vld),
        .i_num   (w_my),
        .i_den   (r_th),
        .i_side  ({r_in_py, w_pos_y, w_neg_y}),
        .o_vld   (w_t_vld_y),
        .o_quo   (w_t_quo_y),
        .o_rem   (w_t_rem_y),
        .o_den   (w_t_den_y),
        .o_side  (w_t_side_y)
    );

    // offset of the point inside its tile, and the saturated index
    t_size         w_qx, w_qy;
    logic [CB-1:0] w_col, w_row;

    assign w_qx = w_t_side_x[0] ? w_t_den_x - SIZE_BITS'(1) - w_t_rem_x
                                : w_t_rem_x + SIZE_BITS'(w_t_side_x[1]);
    assign w_qy = w_t_side_y[0] ? w_t_den_y - SIZE_BITS'(1) - w_t_rem_y
                                : w_t_rem_y + SIZE_BITS'(w_t_side_y[1]);

    always_comb begin
        if (w_t_quo_x[CB-1]) begin
            w_col = w_t_side_x[0] ? COL_MIN : COL_MAX;
        end else begin
            w_col = w_t_side_x[0] ? ~w_t_quo_x : w_t_quo_x;
        end
        if (w_t_quo_y[CB-1]) begin
            w_row = w_t_side_y[0] ? COL_MIN : COL_MAX;
        end else begin
            w_row = w_t_side_y[0] ? ~w_t_quo_y : w_t_quo_y;
        end
    end

    logic          r_m_vld;
    t_size         r_m_qx, r_m_qy;
    logic [CB-1:0] r_m_col, r_m_row, r_m_px, r_m_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= w_t_vld_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_qx  <= w_qx;
        r_m_qy  <= w_qy;
        r_m_col <= w_col;
        r_m_row <= w_row;
        r_m_px  <= w_t_side_x[SIDE1-1:2];
        r_m_py  <= w_t_side_y[SIDE1-1:2];
    end

    // tile corner straight from the in-tile offset
    logic [WIDE-1:0] w_left_w, w_top_w;
    logic            w_zero_x, w_zero_y;

    assign w_left_w = {{(WIDE-CB){r_m_px[CB-1]}}, r_m_px}
                    - {{(WIDE-SIZE_BITS){1'b0}}, r_m_qx};
    assign w_top_w  = {{(WIDE-CB){r_m_py[CB-1]}}, r_m_py}
                    + {{(WIDE-SIZE_BITS){1'b0}}, r_m_qy};
    assign w_zero_x = (r_m_qx == '0);
    assign w_zero_y = (r_m_qy == '0);

    logic             w_p_vld_x, w_p_vld_y;
    t_size            w_p_rem_x, w_p_rem_y, w_p_den_x, w_p_den_y;
    logic [SIDE2-1:0] w_p_side_x, w_p_side_y;

    tgrid_div #(.NUM_BITS(SIZE_BITS), .DEN_BITS(SIZE_BITS), .SIDE_BITS(SIDE2)) u_pix_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m_vld),
        .i_num   (r_m_qx - SIZE_BITS'(1)),
        .i_den   (r_ps),
        .i_side  ({r_m_col, w_left_w[CB:0], r_m_px, w_zero_x}),
        .o_vld   (w_p_vld_x),
        .o_quo   (),
        .o_rem   (w_p_rem_x),
        .o_den   (w_p_den_x),
        .o_side  (w_p_side_x)
    );

    tgrid_div #(.NUM_BITS(SIZE_BITS), .DEN_BITS(SIZE_BITS), .SIDE_BITS(SIDE2)) u_pix_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_m_vld),
        .i_num   (r_m_qy - SIZE_BITS'(1)),
        .i_den   (r_ps),
        .i_side  ({r_m_row, w_top_w[CB:0], r_m_py, w_zero_y}),
        .o_vld   (w_p_vld_y),
        .o_quo   (),
        .o_rem   (w_p_rem_y),
        .o_den   (w_p_den_y),
        .o_side  (w_p_side_y)
    );

    // a point on the tile edge snaps one full pixel past it
    t_size           w_reff_x, w_reff_y;
    logic [CB-1:0]   w_fpx, w_fpy;
    logic [WIDE-1:0] w_sx_w, w_sy_w;

    assign w_reff_x = w_p_side_x[0] ? w_p_den_x - SIZE_BITS'(1) : w_p_rem_x;
    assign w_reff_y = w_p_side_y[0] ? w_p_den_y - SIZE_BITS'(1) : w_p_rem_y;
    assign w_fpx    = w_p_side_x[CB:1];
    assign w_fpy    = w_p_side_y[CB:1];
    assign w_sx_w   = {{(WIDE-CB){w_fpx[CB-1]}}, w_fpx} - WIDE'(1)
                    - {{(WIDE-SIZE_BITS){1'b0}}, w_reff_x};
    assign w_sy_w   = {{(WIDE-CB){w_fpy[CB-1]}}, w_fpy} + WIDE'(1)
                    + {{(WIDE-SIZE_BITS){1'b0}}, w_reff_y};

    logic          r_o_vld;
    logic [CB-1:0] r_o_col, r_o_row;
    logic [CB:0]   r_o_left, r_o_top, r_o_sx, r_o_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else begin
            r_o_vld <= w_p_vld_x;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_col  <= w_p_side_x[SIDE2-1 -: CB];
        r_o_row  <= w_p_side_y[SIDE2-1 -: CB];
        r_o_left <= w_p_side_x[2*CB+1 -: CB+1];
        r_o_top  <= w_p_side_y[2*CB+1 -: CB+1];
        r_o_sx   <= w_sx_w[CB:0];
        r_o_sy   <= w_sy_w[CB:0];
    end

    assign o_valid     = r_o_vld;
    assign o_tile_col  = r_o_col;
    assign o_tile_row  = r_o_row;
    assign o_tile_left = r_o_left;
    assign o_tile_top  = r_o_top;
    assign o_snapped_x = r_o_sx;
    assign o_snapped_y = r_o_sy;

    a_tile_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_t_vld_x == w_t_vld_y)
        else $error("tile divider lanes out of step");

    a_pix_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_p_vld_x == w_p_vld_y)
        else $error("pixel divider lanes out of step");

    a_offset_in_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_t_vld_x |-> (w_qx <= w_t_den_x && w_qy <= w_t_den_y))
        else $error("offset inside tile exceeds tile size");

    a_out_follows_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_vld |=> (u_pix_div_x.r_vld[0] == 1'b1))
        else $error("request lost entering pixel divider");

endmodule

/* tb/map_coord_to_tile_and_pixel_grid_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// map_coord_to_tile_and_pixel_grid_tb
// Drives map points through the tile grid block under several grid setups.
// Each accepted request is predicted here and checked field by field against
// the one-cycle result strobe.
// ----------------------------------------------------------------------------
module map_coord_to_tile_and_pixel_grid_tb;
    import tgrid_pkg::*;

    localparam int  CB       = 48;
    localparam int  LATENCY  = 100;
    localparam int  N_RANDOM = 1130;
    localparam int  N_PHASES = 12;
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    typedef struct {
        logic signed [CB-1:0] col;
        logic signed [CB-1:0] row;
        logic signed [CB:0]   left;
        logic signed [CB:0]   top;
        logic signed [CB:0]   sx;
        logic signed [CB:0]   sy;
    } grid_res_t;

    typedef struct {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        bit                   typed;
        grid_res_t            res;
    } point_row_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic signed [CB-1:0] i_point_x;
    logic signed [CB-1:0] i_point_y;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CB-1:0]        i_cfg_data;
    logic                 o_valid;
    logic signed [CB-1:0] o_tile_col;
    logic signed [CB-1:0] o_tile_row;
    logic signed [CB:0]   o_tile_left;
    logic signed [CB:0]   o_tile_top;
    logic signed [CB:0]   o_snapped_x;
    logic signed [CB:0]   o_snapped_y;

    // typed expectation travels with the request
    bit        use_typed;
    grid_res_t typed_res;

    longint    grid_org_x, grid_org_y, grid_tw, grid_th, grid_ps;
    grid_res_t pending_res[$];
    int        n_errors;

    map_coord_to_tile_and_pixel_grid #(.COORD_BITS(CB)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_tile_col (o_tile_col),
        .o_tile_row (o_tile_row),
        .o_tile_left(o_tile_left),
        .o_tile_top (o_tile_top),
        .o_snapped_x(o_snapped_x),
        .o_snapped_y(o_snapped_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("map_coord_to_tile_and_pixel_grid_tb: errors");
        $finish;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint tile_of(longint d, longint sz);
        return (d > 0) ? floor_div(d - 1, sz) : floor_div(d, sz);
    endfunction

    function automatic logic signed [CB-1:0] clamp_index(longint v);
        if (v > longint'(C_MAX)) return C_MAX;
        if (v < longint'(C_MIN)) return C_MIN;
        return v[CB-1:0];
    endfunction

    function automatic grid_res_t locate_point(longint px, longint py);
        longint    c, r, l, t;
        grid_res_t res;
        c = tile_of(px - grid_org_x, grid_tw);
        r = tile_of(grid_org_y - py, grid_th);
        l = grid_org_x + c * grid_tw;
        t = grid_org_y - r * grid_th;
        res.col  = clamp_index(c);
        res.row  = clamp_index(r);
        res.left = l[CB:0];
        res.top  = t[CB:0];
        res.sx   = 49'(l + floor_div(px - l - 1, grid_ps) * grid_ps);
        res.sy   = 49'(t - floor_div(t - py - 1, grid_ps) * grid_ps);
        return res;
    endfunction

    // capture accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            if (use_typed) pending_res.push_back(typed_res);
            else pending_res.push_back(locate_point(longint'(i_point_x),
                                                    longint'(i_point_y)));
        end
    end

    // check results against the oldest expectation
    always @(posedge i_clk) begin
        grid_res_t e;
        if (i_rst_n && o_valid) begin
            if (pending_res.size() == 0) begin
                $error("result with no request outstanding");
                n_errors++;
            end else begin
                e = pending_res.pop_front();
                if (o_tile_col !== e.col) begin
                    $error("tile_col exp %0d got %0d", e.col, o_tile_col); n_errors++;
                end
                if (o_tile_row !== e.row) begin
                    $error("tile_row exp %0d got %0d", e.row, o_tile_row); n_errors++;
                end
                if (o_tile_left !== e.left) begin
                    $error("tile_left exp %0d got %0d", e.left, o_tile_left); n_errors++;
                end
                if (o_tile_top !== e.top) begin
                    $error("tile_top exp %0d got %0d", e.top, o_tile_top); n_errors++;
                end
                if (o_snapped_x !== e.sx) begin
                    $error("snapped_x exp %0d got %0d", e.sx, o_snapped_x); n_errors++;
                end
                if (o_snapped_y !== e.sy) begin
                    $error("snapped_y exp %0d got %0d", e.sy, o_snapped_y); n_errors++;
                end
            end
        end
    end

    task automatic send_point(logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                              bit typed, grid_res_t res);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        repeat (gap) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_point_x <= px;
        i_point_y <= py;
        use_typed <= typed;
        typed_res <= res;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CB-1:0] data);
        longint sz;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        sz = longint'(data[SIZE_BITS-1:0]);
        if (sz == 0) sz = 1;
        case (idx)
            REG_ORIGIN_X:    grid_org_x = longint'($signed(data));
            REG_ORIGIN_Y:    grid_org_y = longint'($signed(data));
            REG_TILE_WIDTH:  grid_tw = sz;
            REG_TILE_HEIGHT: grid_th = sz;
            REG_PIXEL_SIZE:  grid_ps = sz;
            default: ;
        endcase
    endtask

    function automatic logic [CB-1:0] rand_word();
        return CB'({$urandom, $urandom});
    endfunction

    function automatic logic [CB-1:0] rand_size();
        logic [CB-1:0] v;
        case ($urandom_range(0, 3))
            0: v = rand_word();
            1: v = CB'($urandom_range(0, 8));
            default: v = CB'($urandom_range(1, 2000));
        endcase
        if ($urandom_range(0, 1)) v[CB-1:SIZE_BITS] = (CB-SIZE_BITS)'(rand_word());
        return v;
    endfunction

    // points near tile and pixel lines, plus noise and extremes
    function automatic logic signed [CB-1:0] rand_coord(longint org, longint ts, bit down);
        longint v;
        case ($urandom_range(0, 5))
            0: return rand_word();
            1: begin
                case ($urandom_range(0, 3))
                    0: return C_MAX;
                    1: return C_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: begin
                v = longint'($signed($urandom_range(0, 6)) - 3) * ts
                  + longint'($urandom_range(0, 3)) * grid_ps
                  + longint'($signed($urandom_range(0, 2)) - 1);
                return down ? CB'(org - v) : CB'(org + v);
            end
        endcase
    endfunction

    initial begin
        point_row_t rows[$];
        grid_res_t  none;
        point_row_t r;
        int         per_phase;

        n_errors   = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_point_x  = '0;
        i_point_y  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_ORIGIN_X;
        i_cfg_data = '0;
        use_typed  = 1'b0;
        typed_res  = none;
        grid_org_x = 0;
        grid_org_y = 0;
        grid_tw    = 256;
        grid_th    = 256;
        grid_ps    = 256;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid: origin 0, all sizes 256
        rows.push_back('{48'sd0,    48'sd0,   1, '{0, 0, 0,   0, -256, 256}});
        rows.push_back('{48'sd256,  -48'sd256, 1, '{0, 0, 0,   0, 0,    0}});
        rows.push_back('{48'sd1,    -48'sd1,  1, '{0, 0, 0,   0, 0,    0}});
        rows.push_back('{48'sd257,  48'sd0,   1, '{1, 0, 256, 0, 256,  256}});
        rows.push_back('{-48'sd1,   48'sd1,   1, '{-1, -1, -256, 256, -256, 256}});
        rows.push_back('{C_MAX, C_MAX, 0, none});
        rows.push_back('{C_MIN, C_MIN, 0, none});
        rows.push_back('{C_MAX, C_MIN, 0, none});
        rows.push_back('{C_MIN, C_MAX, 0, none});
        rows.push_back('{48'sd512,  -48'sd513, 0, none});
        foreach (rows[i]) begin
            r = rows[i];
            send_point(r.px, r.py, r.typed, r.res);
        end
        // hold off until the pipe is empty
        drain();

        per_phase = N_RANDOM / N_PHASES;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin
                    // unit sizes at opposite origins push the index past range
                    write_reg(REG_ORIGIN_X, C_MAX);
                    write_reg(REG_ORIGIN_Y, C_MIN);
                    write_reg(REG_TILE_WIDTH, '0);
                    write_reg(REG_TILE_HEIGHT, 48'hFE00_0000_0000);
                    write_reg(REG_PIXEL_SIZE, 48'd1);
                end
                1: begin
                    write_reg(REG_ORIGIN_X, C_MIN);
                    write_reg(REG_ORIGIN_Y, C_MAX);
                    write_reg(REG_PIXEL_SIZE, '0);
                end
                2: begin
                    write_reg(REG_ORIGIN_X, '0);
                    write_reg(REG_ORIGIN_Y, '0);
                    write_reg(REG_TILE_WIDTH, 48'h100_0000_0000);
                    write_reg(REG_TILE_HEIGHT, 48'h100_0000_0000);
                    write_reg(REG_PIXEL_SIZE, 48'h1FF_FFFF_FFFF);
                end
                default: begin
                    write_reg(REG_ORIGIN_X, rand_word());
                    write_reg(REG_ORIGIN_Y, rand_word());
                    write_reg(REG_TILE_WIDTH, rand_size());
                    write_reg(REG_TILE_HEIGHT, rand_size());
                    write_reg(REG_PIXEL_SIZE, rand_size());
                    // unmapped indexes must leave the grid alone
                    write_reg(CFG_IDX_W'($urandom_range(5, 7)), rand_word());
                end
            endcase
            repeat (per_phase) begin
                send_point(rand_coord(grid_org_x, grid_tw, 1'b0),
                           rand_coord(grid_org_y, grid_th, 1'b1), 1'b0, none);
            end
            // back-to-back burst with no gaps
            repeat (8) begin
                start     <= 1'b1;
                i_point_x <= rand_word();
                i_point_y <= rand_word();
                use_typed <= 1'b0;
                @(negedge i_clk);
                while (busy) @(negedge i_clk);
                @(posedge i_clk);
            end
            drain();
        end

        if (n_errors == 0) begin
            $display("map_coord_to_tile_and_pixel_grid_tb: clean");
        end else begin
            $display("map_coord_to_tile_and_pixel_grid_tb: errors");
        end
        $finish;
    end

endmodule
